@@ hw/rtl/ltm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ltm_pkg
// Shared types, constants and the microcode program of the tremolo modulator.
// ----------------------------------------------------------------------------
package ltm_pkg;

  localparam logic [16:0] Q16_ONE = 17'h10000;
  localparam longint Q30 = 64'sd1073741824;

  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEPTH      = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PHASE_STEP = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WAVEFORM   = 2'd2;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SQUARE = 2'd1,
    WAVE_TRI    = 2'd2,
    WAVE_SAW    = 2'd3
  } wave_e;

  typedef enum logic [1:0] {
    JMP_NEXT     = 2'd0,
    JMP_WAIT_IN  = 2'd1,
    JMP_WAIT_OUT = 2'd2
  } jmp_e;

  typedef enum logic [2:0] {
    MUL_NONE  = 3'd0,
    MUL_WAVE  = 3'd1,
    MUL_GAIN  = 3'd2,
    MUL_LEFT  = 3'd3,
    MUL_RIGHT = 3'd4
  } mul_sel_e;

  localparam int unsigned STEP_BITS = 4;
  localparam logic [STEP_BITS-1:0] STEP_IDLE  = 4'd0;
  localparam logic [STEP_BITS-1:0] STEP_WMUL  = 4'd1;
  localparam logic [STEP_BITS-1:0] STEP_ROMRD = 4'd2;
  localparam logic [STEP_BITS-1:0] STEP_WAVE  = 4'd3;
  localparam logic [STEP_BITS-1:0] STEP_GMUL  = 4'd4;
  localparam logic [STEP_BITS-1:0] STEP_GAIN  = 4'd5;
  localparam logic [STEP_BITS-1:0] STEP_LMUL  = 4'd6;
  localparam logic [STEP_BITS-1:0] STEP_RMUL  = 4'd7;
  localparam logic [STEP_BITS-1:0] STEP_DONE  = 4'd8;

  typedef struct packed {
    jmp_e                 jmp;
    logic [STEP_BITS-1:0] target;
    mul_sel_e             mul_sel;
    logic                 ld_in;
    logic                 ld_prod;
    logic                 ld_wave;
    logic                 ld_gain;
    logic                 ld_left;
    logic                 ld_out;
  } ctrl_t;

  function automatic ctrl_t ucode_word(input logic [STEP_BITS-1:0] step);
    ctrl_t w;
    w = '{jmp: JMP_NEXT, target: STEP_IDLE, mul_sel: MUL_NONE, default: 1'b0};
    case (step)
      STEP_IDLE: begin
        w.jmp   = JMP_WAIT_IN;
        w.ld_in = 1'b1;
      end
      STEP_WMUL: begin
        w.mul_sel = MUL_WAVE;
        w.ld_prod = 1'b1;
      end
      STEP_ROMRD: begin
      end
      STEP_WAVE: begin
        w.ld_wave = 1'b1;
      end
      STEP_GMUL: begin
        w.mul_sel = MUL_GAIN;
        w.ld_prod = 1'b1;
      end
      STEP_GAIN: begin
        w.ld_gain = 1'b1;
      end
      STEP_LMUL: begin
        w.mul_sel = MUL_LEFT;
        w.ld_prod = 1'b1;
      end
      STEP_RMUL: begin
        w.mul_sel = MUL_RIGHT;
        w.ld_prod = 1'b1;
        w.ld_left = 1'b1;
      end
      STEP_DONE: begin
        w.jmp    = JMP_WAIT_OUT;
        w.target = STEP_IDLE;
        w.ld_out = 1'b1;
      end
      default: begin
        w.jmp    = JMP_WAIT_OUT;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic logic [16:0] sine_poly(input longint x);
    longint x2;
    longint p;
    longint s;
    x2 = (x * x) / Q30;
    p = 64'sd172272;
    p = -64'sd5026995 + (p * x2) / Q30;
    p = 64'sd85569306 + (p * x2) / Q30;
    p = -64'sd693598668 + (p * x2) / Q30;
    p = 64'sd1686629713 + (p * x2) / Q30;
    s = (p * x) / Q30;
    if (s < 0) begin
      s = 0;
    end
    s = (s + 64'sd8192) / 64'sd16384;
    if (s > 64'sd65536) begin
      s = 64'sd65536;
    end
    return s[16:0];
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/lfo_tremolo_modulator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lfo_tremolo_modulator
// Stereo tremolo: LFO wave scales both channels by 1 - depth + depth * wave.
// ----------------------------------------------------------------------------
// Frames run through the nine-step microcode program, which shares one
// multiplier; the next frame is taken only once the last has passed the
// DONE step, which stalls while the previous result has not been taken.
// A finished result waits in the output register; the next frame is taken.
// Reset clears the configuration registers, the LFO phase and the sequencer.
module lfo_tremolo_modulator #(
  parameter int unsigned SAMPLE_BITS      = 24,
  parameter int unsigned PHASE_BITS       = 24,
  parameter int unsigned SINE_TABLE_DEPTH = 256,
  localparam int unsigned CFG_W = (PHASE_BITS > 17) ? PHASE_BITS : 17
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [ltm_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  wire logic [CFG_W-1:0]                    cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0]       left_in_i,
  input  wire logic signed [SAMPLE_BITS-1:0]       right_in_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]            left_out_o,
  output logic signed [SAMPLE_BITS-1:0]            right_out_o
);

  logic [16:0]           depth_q;
  logic [PHASE_BITS-1:0] phase_step_q;
  ltm_pkg::wave_e        waveform_q;
  logic [16:0]           depth_sat;
  logic                  out_valid_q, out_valid_d;
  logic                  out_busy;
  logic                  go;
  ltm_pkg::ctrl_t        ctrl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q      <= '0;
      phase_step_q <= '0;
      waveform_q   <= ltm_pkg::WAVE_SINE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ltm_pkg::CFG_DEPTH: begin
          depth_q <= cfg_data_i[16:0];
        end
        ltm_pkg::CFG_PHASE_STEP: begin
          phase_step_q <= cfg_data_i[PHASE_BITS-1:0];
        end
        ltm_pkg::CFG_WAVEFORM: begin
          waveform_q <= ltm_pkg::wave_e'(cfg_data_i[1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  assign depth_sat = (depth_q > ltm_pkg::Q16_ONE) ? ltm_pkg::Q16_ONE : depth_q;

  assign out_busy    = out_valid_q && !out_ready_i;
  assign out_valid_d = (ctrl.ld_out && go) ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  ltm_sequencer u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .out_busy_i(out_busy),
    .ctrl_o    (ctrl),
    .go_o      (go),
    .in_ready_o(in_ready_o)
  );

  ltm_datapath #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .go_i        (go),
    .waveform_i  (waveform_q),
    .depth_i     (depth_sat),
    .phase_step_i(phase_step_q),
    .left_in_i   (left_in_i),
    .right_in_i  (right_in_i),
    .left_out_o  (left_out_o),
    .right_out_o (right_out_o)
  );

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

@@ hw/rtl/ltm_sine_rom.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ltm_sine_rom
// Quarter-wave sine table in Q16 with a registered read port.
// ----------------------------------------------------------------------------
module ltm_sine_rom #(
  parameter int unsigned SINE_TABLE_DEPTH = 256,
  localparam int unsigned AW = $clog2(SINE_TABLE_DEPTH + 1)
) (
  input  wire logic          clk_i,
  input  wire logic [AW-1:0] addr_i,
  output logic [16:0]        data_o
);

  function automatic logic [16:0] entry(input int k);
    longint x;
    x = (longint'(k) * ltm_pkg::Q30) / SINE_TABLE_DEPTH;
    return ltm_pkg::sine_poly(x);
  endfunction

  logic [16:0] rom [SINE_TABLE_DEPTH+1];
  logic [16:0] data_q;

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
    assign rom[k] = entry(k);
  end

  always_ff @(posedge clk_i) begin
    data_q <= rom[addr_i];
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

@@ hw/rtl/ltm_sequencer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ltm_sequencer
// Step counter over the microcode program with conditional jumps.
// ----------------------------------------------------------------------------
module ltm_sequencer (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      out_busy_i,
  output ltm_pkg::ctrl_t ctrl_o,
  output logic           go_o,
  output logic           in_ready_o
);

  logic [ltm_pkg::STEP_BITS-1:0] step_q, step_d;
  ltm_pkg::ctrl_t word;

  assign word = ltm_pkg::ucode_word(step_q);

  always_comb begin
    go_o   = 1'b1;
    step_d = step_q + 1'b1;
    case (word.jmp)
      ltm_pkg::JMP_NEXT: begin
        go_o   = 1'b1;
        step_d = step_q + 1'b1;
      end
      ltm_pkg::JMP_WAIT_IN: begin
        go_o   = in_valid_i;
        step_d = in_valid_i ? step_q + 1'b1 : step_q;
      end
      ltm_pkg::JMP_WAIT_OUT: begin
        go_o   = !out_busy_i;
        step_d = out_busy_i ? step_q : word.target;
      end
      default: begin
        go_o   = 1'b0;
        step_d = ltm_pkg::STEP_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ltm_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o     = word;
  assign in_ready_o = (word.jmp == ltm_pkg::JMP_WAIT_IN);

endmodule
`default_nettype wire

@@ hw/rtl/ltm_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ltm_datapath
// Phase accumulator, wave shaping, shared multiplier and output registers.
// ----------------------------------------------------------------------------
module ltm_datapath #(
  parameter int unsigned SAMPLE_BITS      = 24,
  parameter int unsigned PHASE_BITS       = 24,
  parameter int unsigned SINE_TABLE_DEPTH = 256
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ltm_pkg::ctrl_t                ctrl_i,
  input  wire logic                          go_i,
  input  wire ltm_pkg::wave_e                waveform_i,
  input  wire logic [16:0]                   depth_i,
  input  wire logic [PHASE_BITS-1:0]         phase_step_i,
  input  wire logic signed [SAMPLE_BITS-1:0] left_in_i,
  input  wire logic signed [SAMPLE_BITS-1:0] right_in_i,
  output logic signed [SAMPLE_BITS-1:0]      left_out_o,
  output logic signed [SAMPLE_BITS-1:0]      right_out_o
);

  localparam int unsigned P  = PHASE_BITS;
  localparam int unsigned S  = SAMPLE_BITS;
  localparam int unsigned AW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned MX = (S > P) ? S : P;
  localparam int unsigned MW = ((MX > 17) ? MX : 17) + 1;
  localparam int unsigned MB = 18;
  localparam int unsigned PW = MW + MB;

  localparam logic [P-1:0] HALF    = P'(1) << (P - 1);
  localparam logic [P-1:0] QUARTER = P'(1) << (P - 2);
  localparam logic [P-1:0] QUART3  = P'(3) << (P - 2);
  localparam logic [P-1:0] SQ_A    = P'((64'd48 << P) / 64'd100);
  localparam logic [P-1:0] SQ_C    = P'((64'd98 << P) / 64'd100);

  logic [P-1:0]          phase_q;
  logic signed [S-1:0]   left_q, right_q;
  logic signed [PW-1:0]  prod_q;
  logic [16:0]           wave_q, wave_d;
  logic [16:0]           gain_q, gain_d;
  logic [S-1:0]          left_res_q;
  logic signed [S-1:0]   left_out_q, right_out_q;

  logic signed [MW-1:0]  mul_a;
  logic signed [MB-1:0]  mul_b;
  logic signed [PW-1:0]  prod_d;

  logic [1:0]            quad;
  logic [AW-1:0]         sine_idx, rom_addr;
  logic [16:0]           rom_data;
  logic [P-1:0]          sq_off, tri_off;
  logic [P+21:0]         sq_wide;
  logic [P+16:0]         tri_wide;
  logic [P+15:0]         saw_wide;
  logic [17:0]           sine_sum;
  logic signed [PW-1:0]  biased;
  logic [S-1:0]          scaled;
  logic [P:0]            phase_sum;

  assign quad   = phase_q[P-1:P-2];
  assign sq_off = (phase_q < HALF) ? phase_q - SQ_A : phase_q - SQ_C;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl_i.mul_sel)
      ltm_pkg::MUL_WAVE: begin
        case (waveform_i)
          ltm_pkg::WAVE_SINE: begin
            mul_a = MW'(phase_q[P-3:0]);
            mul_b = MB'(SINE_TABLE_DEPTH);
          end
          ltm_pkg::WAVE_SQUARE: begin
            mul_a = MW'(sq_off);
            mul_b = MB'(50);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      ltm_pkg::MUL_GAIN: begin
        mul_a = MW'(depth_i);
        mul_b = MB'(wave_q);
      end
      ltm_pkg::MUL_LEFT: begin
        mul_a = MW'(left_q);
        mul_b = MB'(gain_q);
      end
      ltm_pkg::MUL_RIGHT: begin
        mul_a = MW'(right_q);
        mul_b = MB'(gain_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = PW'(mul_a) * PW'(mul_b);

  assign sine_idx = AW'($unsigned(prod_q) >> (P - 2));
  assign rom_addr = quad[0] ? AW'(SINE_TABLE_DEPTH) - sine_idx : sine_idx;

  ltm_sine_rom #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_rom (
    .clk_i (clk_i),
    .addr_i(rom_addr),
    .data_o(rom_data)
  );

  assign sine_sum = quad[1] ? 18'(ltm_pkg::Q16_ONE) - 18'(rom_data)
                            : 18'(ltm_pkg::Q16_ONE) + 18'(rom_data);
  assign sq_wide  = {prod_q[P+5:0], 16'b0} >> P;

  always_comb begin
    if (phase_q < QUARTER) begin
      tri_off = phase_q;
    end else if (phase_q < QUART3) begin
      tri_off = phase_q - QUARTER;
    end else begin
      tri_off = phase_q - QUART3;
    end
  end

  assign tri_wide = {tri_off, 17'b0} >> P;
  assign saw_wide = {phase_q, 16'b0} >> P;

  always_comb begin
    wave_d = '0;
    case (waveform_i)
      ltm_pkg::WAVE_SINE: begin
        wave_d = sine_sum[17:1];
      end
      ltm_pkg::WAVE_SQUARE: begin
        if (phase_q < SQ_A) begin
          wave_d = ltm_pkg::Q16_ONE;
        end else if (phase_q < HALF) begin
          if (sq_wide >= (P+22)'(ltm_pkg::Q16_ONE)) begin
            wave_d = '0;
          end else begin
            wave_d = ltm_pkg::Q16_ONE - sq_wide[16:0];
          end
        end else if (phase_q < SQ_C) begin
          wave_d = '0;
        end else if (sq_wide >= (P+22)'(ltm_pkg::Q16_ONE)) begin
          wave_d = ltm_pkg::Q16_ONE;
        end else begin
          wave_d = sq_wide[16:0];
        end
      end
      ltm_pkg::WAVE_TRI: begin
        if (phase_q < QUARTER) begin
          wave_d = 17'd32768 + tri_wide[16:0];
        end else if (phase_q < QUART3) begin
          wave_d = ltm_pkg::Q16_ONE - tri_wide[16:0];
        end else begin
          wave_d = tri_wide[16:0];
        end
      end
      ltm_pkg::WAVE_SAW: begin
        if (phase_q < HALF) begin
          wave_d = 17'd32768 - saw_wide[16:0];
        end else begin
          wave_d = 17'd98304 - saw_wide[16:0];
        end
      end
      default: begin
        wave_d = '0;
      end
    endcase
  end

  assign gain_d = 17'(18'(ltm_pkg::Q16_ONE) - 18'(depth_i) + 18'(prod_q[32:16]));

  // Products are divided by 65536 with truncation toward zero.
  assign biased = prod_q + (prod_q[PW-1] ? PW'(65535) : PW'(0));
  assign scaled = biased[S+15:16];

  assign phase_sum = {1'b0, phase_q} + {1'b0, phase_step_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (ctrl_i.ld_out && go_i) begin
      phase_q <= phase_sum[P] ? '0 : phase_sum[P-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_in && go_i) begin
      left_q  <= left_in_i;
      right_q <= right_in_i;
    end
    if (ctrl_i.ld_prod && go_i) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.ld_wave && go_i) begin
      wave_q <= wave_d;
    end
    if (ctrl_i.ld_gain && go_i) begin
      gain_q <= gain_d;
    end
    if (ctrl_i.ld_left && go_i) begin
      left_res_q <= scaled;
    end
    if (ctrl_i.ld_out && go_i) begin
      left_out_q  <= $signed(left_res_q);
      right_out_q <= $signed(scaled);
    end
  end

  assign left_out_o  = left_out_q;
  assign right_out_o = right_out_q;

endmodule
`default_nettype wire

@@ test/lfo_tremolo_modulator_checker.sv @@
// ----------------------------------------------------------------------------
// lfo_tremolo_modulator_checker
// Watches the configuration port and both frame channels of the tremolo
// modulator. It keeps its own copy of the registers and the LFO phase,
// predicts the modulated frame for every input transfer, and compares
// each output transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module lfo_tremolo_modulator_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [23:0] left_in_i,
  input  logic [23:0] right_in_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [23:0] left_out_i,
  input  logic [23:0] right_out_i,
  output int          fail_count_o,
  output int          outstanding_o
);

  localparam longint UNITY       = 65536;
  localparam longint Q30_SCALE   = 64'sd1073741824;
  localparam int     TABLE_DEPTH = 256;
  localparam longint PHASE_FULL  = 64'd1 << 24;
  localparam longint QUARTER     = PHASE_FULL / 4;
  localparam longint HALF        = PHASE_FULL / 2;
  localparam longint SQ_FALL     = (64'd48 << 24) / 100;
  localparam longint SQ_RISE     = (64'd98 << 24) / 100;

  typedef struct packed {
    logic [23:0] left;
    logic [23:0] right;
  } stereo_frame_t;

  logic [16:0]    sine_quarter [0:TABLE_DEPTH];
  logic [16:0]    depth_q;
  logic [23:0]    step_q;
  ltm_pkg::wave_e wave_q;
  logic [23:0]    phase_q;
  logic [24:0]    phase_sum;
  stereo_frame_t  expected_frames [$];
  stereo_frame_t  oldest;

  function automatic logic [16:0] quarter_sine_at(input int k);
    longint coef [5];
    longint x;
    longint x2;
    longint acc;
    longint s;
    coef = '{64'sd172272, -64'sd5026995, 64'sd85569306, -64'sd693598668,
             64'sd1686629713};
    x = (longint'(k) * Q30_SCALE) / TABLE_DEPTH;
    x2 = (x * x) / Q30_SCALE;
    acc = coef[0];
    for (int i = 1; i < 5; i++) begin
      acc = coef[i] + (acc * x2) / Q30_SCALE;
    end
    s = (acc * x) / Q30_SCALE;
    if (s < 0) begin
      s = 0;
    end
    s = (s + 8192) / 16384;
    if (s > UNITY) begin
      s = UNITY;
    end
    return 17'(s);
  endfunction

  function automatic longint wave_level(input logic [23:0] ph,
                                        input ltm_pkg::wave_e shape);
    longint p;
    longint idx;
    longint s;
    longint v;
    p = longint'(ph);
    case (shape)
      ltm_pkg::WAVE_SINE: begin
        idx = (longint'(ph[21:0]) * TABLE_DEPTH) >> 22;
        s = ph[22] ? longint'(sine_quarter[TABLE_DEPTH - idx])
                   : longint'(sine_quarter[idx]);
        v = ph[23] ? (UNITY - s) / 2 : (UNITY + s) / 2;
      end
      ltm_pkg::WAVE_SQUARE: begin
        if (p < SQ_FALL) begin
          v = UNITY;
        end else if (p < HALF) begin
          v = UNITY - ((50 * (p - SQ_FALL) * UNITY) >> 24);
        end else if (p < SQ_RISE) begin
          v = 0;
        end else begin
          v = (50 * (p - SQ_RISE) * UNITY) >> 24;
        end
      end
      ltm_pkg::WAVE_TRI: begin
        if (p < QUARTER) begin
          v = 32768 + ((p << 17) >> 24);
        end else if (p < 3 * QUARTER) begin
          v = UNITY - (((p - QUARTER) << 17) >> 24);
        end else begin
          v = ((p - 3 * QUARTER) << 17) >> 24;
        end
      end
      default: begin
        if (p < HALF) begin
          v = 32768 - ((p << 16) >> 24);
        end else begin
          v = 98304 - ((p << 16) >> 24);
        end
      end
    endcase
    if (v < 0) begin
      v = 0;
    end
    if (v > UNITY) begin
      v = UNITY;
    end
    return v;
  endfunction

  function automatic logic [23:0] scale_sample(input logic [23:0] smp, input longint gain);
    longint prod;
    prod = (longint'($signed(smp)) * gain) / UNITY;
    return 24'(prod);
  endfunction

  function automatic stereo_frame_t modulate_frame(input logic [23:0] l, input logic [23:0] r);
    longint d;
    longint gain;
    stereo_frame_t f;
    d = (longint'(depth_q) > UNITY) ? UNITY : longint'(depth_q);
    gain = UNITY - d + ((d * wave_level(phase_q, wave_q)) >> 16);
    f.left = scale_sample(l, gain);
    f.right = scale_sample(r, gain);
    return f;
  endfunction

  initial begin
    for (int k = 0; k <= TABLE_DEPTH; k++) begin
      sine_quarter[k] = quarter_sine_at(k);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q = '0;
      step_q = '0;
      wave_q = ltm_pkg::WAVE_SINE;
      phase_q = '0;
      expected_frames.delete();
      fail_count_o = 0;
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_frames.size() == 0) begin
          $display("%0t: result transfer with none expected, got left %0d right %0d",
                   $time, $signed(left_out_i), $signed(right_out_i));
          fail_count_o++;
        end else begin
          oldest = expected_frames.pop_front();
          if (left_out_i !== oldest.left) begin
            $display("%0t: left_out expected %0d, got %0d",
                     $time, $signed(oldest.left), $signed(left_out_i));
            fail_count_o++;
          end
          if (right_out_i !== oldest.right) begin
            $display("%0t: right_out expected %0d, got %0d",
                     $time, $signed(oldest.right), $signed(right_out_i));
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_frames.push_back(modulate_frame(left_in_i, right_in_i));
        phase_sum = {1'b0, phase_q} + {1'b0, step_q};
        phase_q = phase_sum[24] ? '0 : phase_sum[23:0];
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ltm_pkg::CFG_DEPTH:      depth_q = cfg_data_i[16:0];
          ltm_pkg::CFG_PHASE_STEP: step_q = cfg_data_i;
          ltm_pkg::CFG_WAVEFORM:   wave_q = ltm_pkg::wave_e'(cfg_data_i[1:0]);
          default: ;
        endcase
      end
      outstanding_o <= expected_frames.size();
    end
  end

endmodule

@@ test/lfo_tremolo_modulator_test.sv @@
// ----------------------------------------------------------------------------
// lfo_tremolo_modulator_test
// Drives stereo frames and register writes into the tremolo modulator with
// bursty input and a stalling output side, and lets a separate checker
// predict and compare every result frame before giving the verdict.
// ----------------------------------------------------------------------------
module lfo_tremolo_modulator_test;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 300;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [1:0]         cfg_idx_i   = ltm_pkg::CFG_DEPTH;
  logic [23:0]        cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic signed [23:0] left_in_i   = '0;
  logic signed [23:0] right_in_i  = '0;
  logic               out_ready_i = 1'b0;
  logic               in_ready_o;
  logic               out_valid_o;
  logic signed [23:0] left_out_o;
  logic signed [23:0] right_out_o;

  int  fail_count;
  int  outstanding;
  int  cycle_count  = 0;
  int  burst_left   = 0;
  bit  calm_mode    = 1'b0;
  bit  hold_req     = 1'b0;
  bit  rx_hold_seen = 1'b0;
  int  rx_hold_left = 0;
  int  rx_run_left  = 0;

  ltm_pkg::wave_e shape_list [4] = '{ltm_pkg::WAVE_SINE, ltm_pkg::WAVE_SQUARE,
                                     ltm_pkg::WAVE_TRI, ltm_pkg::WAVE_SAW};

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  lfo_tremolo_modulator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .left_in_i   (left_in_i),
    .right_in_i  (right_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .left_out_o  (left_out_o),
    .right_out_o (right_out_o)
  );

  lfo_tremolo_modulator_checker frame_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .left_in_i     (left_in_i),
    .right_in_i    (right_in_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .left_out_i    (left_out_o),
    .right_out_i   (right_out_o),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // Outside calm mode the receiver alternates ready and stall runs; a toggle
  // of hold_req makes it refuse every transfer for a long stretch.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_hold_left = 0;
      rx_run_left = 0;
      rx_hold_seen = 1'b0;
    end else begin
      if (hold_req != rx_hold_seen) begin
        rx_hold_seen = hold_req;
        rx_hold_left = HOLD_CYCLES;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ready_i <= 1'b0;
      end else if (calm_mode) begin
        out_ready_i <= 1'b1;
      end else if (rx_run_left > 0) begin
        rx_run_left--;
      end else if (out_ready_i) begin
        out_ready_i <= 1'b0;
        rx_run_left = $urandom_range(0, 7);
      end else begin
        out_ready_i <= 1'b1;
        rx_run_left = $urandom_range(0, 24);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("lfo_tremolo_modulator test failed");
      $finish;
    end
  end

  task automatic send_frame(input logic [23:0] l, input logic [23:0] r);
    int gap;
    if (!calm_mode && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 4);
      burst_left = $urandom_range(1, 16);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    in_valid_i <= 1'b1;
    left_in_i <= l;
    right_in_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [23:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($signed($urandom_range(0, 4)) - 2);
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic random_setting();
    logic [23:0] depth_val;
    logic [23:0] step_val;
    logic [23:0] wave_val;
    case ($urandom_range(0, 4))
      0: depth_val = '0;
      1: depth_val = 24'(ltm_pkg::Q16_ONE);
      2: depth_val = 24'($urandom_range(0, 65536));
      3: depth_val = 24'($urandom_range(65537, 131071));
      default: depth_val = 24'($urandom());
    endcase
    case ($urandom_range(0, 5))
      0: step_val = '0;
      1: step_val = 24'hFFFFFF;
      2: step_val = 24'h1 << $urandom_range(10, 23);
      3: step_val = 24'($urandom_range(1, 24'h3FFFF));
      default: step_val = 24'($urandom());
    endcase
    wave_val = {($urandom_range(0, 1) != 0) ? 22'($urandom()) : 22'd0,
                2'(shape_list[$urandom_range(0, 3)])};
    write_reg(ltm_pkg::CFG_DEPTH, depth_val);
    write_reg(ltm_pkg::CFG_PHASE_STEP, step_val);
    write_reg(ltm_pkg::CFG_WAVEFORM, wave_val);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_frame(24'h7FFFFF, 24'h800000);
    send_frame(pick_sample(), pick_sample());
    wait_drained();

    write_reg(ltm_pkg::CFG_DEPTH, 24'(ltm_pkg::Q16_ONE));
    write_reg(ltm_pkg::CFG_PHASE_STEP, 24'h400000);
    for (int s = 0; s < 4; s++) begin
      write_reg(ltm_pkg::CFG_WAVEFORM, 24'(shape_list[s]));
      send_frame(24'h7FFFFF, 24'h800000);
      send_frame(24'h800000, 24'h7FFFFF);
      send_frame(24'hFFFFFF, 24'h000001);
      send_frame(24'h000000, 24'hFFFFFF);
      send_frame(pick_sample(), pick_sample());
      wait_drained();
    end

    write_reg(ltm_pkg::CFG_DEPTH, 24'h01FFFF);
    send_frame(24'h7FFFFF, 24'h800000);
    send_frame(pick_sample(), pick_sample());
    wait_drained();

    for (int phase_n = 0; phase_n < 12; phase_n++) begin
      calm_mode <= (phase_n == 3);
      if (phase_n == 0) begin
        write_reg(ltm_pkg::CFG_DEPTH, 24'(ltm_pkg::Q16_ONE));
        write_reg(ltm_pkg::CFG_PHASE_STEP, 24'hFFFFFF);
        write_reg(ltm_pkg::CFG_WAVEFORM, 24'(shape_list[$urandom_range(0, 3)]));
      end else if (phase_n == 1) begin
        write_reg(ltm_pkg::CFG_DEPTH, 24'h01FFFF);
        write_reg(ltm_pkg::CFG_PHASE_STEP, 24'h000000);
        write_reg(ltm_pkg::CFG_WAVEFORM, 24'(shape_list[$urandom_range(0, 3)]));
      end else begin
        random_setting();
      end
      for (int n = 0; n < 100; n++) begin
        if (phase_n == 5 && n == 10) begin
          hold_req <= ~hold_req;
        end
        if (phase_n == 7 && n == 50) begin
          wait_drained();
        end
        send_frame(pick_sample(), pick_sample());
      end
      wait_drained();
    end

    if (fail_count == 0 && outstanding == 0) begin
      $display("lfo_tremolo_modulator test passed");
    end else begin
      $display("lfo_tremolo_modulator test failed");
    end
    $finish;
  end

endmodule

@@ lfo_tremolo_modulator.f @@
hw/rtl/ltm_pkg.sv
hw/rtl/ltm_sine_rom.sv
hw/rtl/ltm_sequencer.sv
hw/rtl/ltm_datapath.sv
hw/rtl/lfo_tremolo_modulator.sv
test/lfo_tremolo_modulator_checker.sv
test/lfo_tremolo_modulator_test.sv
